>>> hdl/lmss_pkg.sv
`timescale 1ns / 1ps

package lmss_pkg;

  // Column store geometry; the depth is a power of two so the scan index
  // wraps by truncation.
  localparam int PATTERN_DEPTH = 128;
  localparam int ADDR_W        = $clog2(PATTERN_DEPTH);
  localparam int CMP_W         = ADDR_W + 8;

  // Field and register widths
  localparam int LINE_W  = 3;
  localparam int DIV_W   = 8;
  localparam int SCROLL_W = 7;
  localparam int MODE_W  = 4;
  localparam int IN_ADDR_W = 7;

  // Command codes
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Configuration register indexes
  localparam logic REG_SPEED_DIVIDER = 1'b0;
  localparam logic REG_SCROLL_LAST   = 1'b1;

  // Reset values of the configuration registers
  localparam logic [DIV_W-1:0]    SPEED_DIVIDER_RESET = 8'd50;
  localparam logic [SCROLL_W-1:0] SCROLL_LAST_RESET   = 7'd79;

  // Color modes, named by (row_drive, second_drive)
  localparam logic [MODE_W-1:0] MODE_D_FF   = 4'd0;
  localparam logic [MODE_W-1:0] MODE_FF_D   = 4'd1;
  localparam logic [MODE_W-1:0] MODE_D_D    = 4'd2;
  localparam logic [MODE_W-1:0] MODE_ND_FF  = 4'd3;
  localparam logic [MODE_W-1:0] MODE_00_D   = 4'd4;
  localparam logic [MODE_W-1:0] MODE_ND_D   = 4'd5;
  localparam logic [MODE_W-1:0] MODE_00_ND  = 4'd6;
  localparam logic [MODE_W-1:0] MODE_ND_ND  = 4'd7;
  localparam logic [MODE_W-1:0] MODE_ND_00  = 4'd8;
  localparam logic [MODE_W-1:0] MODE_D_ND   = 4'd9;
  localparam logic [MODE_W-1:0] MODE_D_00   = 4'd10;
  localparam logic [MODE_W-1:0] MODE_FF_ND  = 4'd11;
  localparam logic [MODE_W-1:0] MODE_LAST   = MODE_FF_ND;

  // Reverse the bit order of a byte
  function automatic logic [7:0] flip_bits(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[7-k] = v[k];
    end
    return r;
  endfunction

endpackage

>>> hdl/lmss_column_store.sv
`timescale 1ns / 1ps

module lmss_column_store (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        write_en,
  input  logic [lmss_pkg::ADDR_W-1:0] write_addr,
  input  logic [7:0]                  write_data,
  input  logic                        read_en,
  input  logic [lmss_pkg::ADDR_W-1:0] read_addr,
  output logic [7:0]                  read_data
);
  import lmss_pkg::*;

  logic [7:0]               mem [PATTERN_DEPTH];
  logic [PATTERN_DEPTH-1:0] valid;
  logic [7:0]               data_q;
  logic                     hit_q;

  // Write the pattern memory
  always_ff @(posedge clk) begin
    if (write_en) begin
      mem[write_addr] <= write_data;
    end
  end

  // Track written entries; an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (write_en) begin
      valid[write_addr] <= 1'b1;
    end
  end

  // Register the read port
  always_ff @(posedge clk) begin
    if (read_en) begin
      data_q <= mem[read_addr];
      hit_q  <= valid[read_addr];
    end
  end

  assign read_data = hit_q ? data_q : 8'h00;

endmodule

>>> hdl/led_matrix_scroll_scanner.sv
`timescale 1ns / 1ps

// Scan engine for an 8x8 two-color LED matrix that scrolls a message held in
// a column pattern store (lmss_pkg::PATTERN_DEPTH bytes, reads as zero after
// reset). A write transaction (command 1) stores one column byte and gives no
// result; a tick transaction (command 0) gives one scan line: the row drives
// for the current color mode, the active-low line select and the mode. The
// block takes one transaction per cycle while in_stall is low; a tick result
// passes through the registered store read and then the output register. A
// write is visible to a tick accepted in the next cycle.
// Configuration registers: index 0 speed_divider, index 1 scroll_last.
module led_matrix_scroll_scanner (
  input  logic                          clk,
  input  logic                          rst,
  // configuration port
  input  logic                          cfg_write_enable,
  input  logic                          cfg_index,
  input  logic [7:0]                    cfg_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          command,
  input  logic [lmss_pkg::IN_ADDR_W-1:0] address,
  input  logic [7:0]                    pattern_byte,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    row_drive,
  output logic [7:0]                    second_drive,
  output logic [7:0]                    scan_select,
  output logic [lmss_pkg::MODE_W-1:0]   color_mode
);
  import lmss_pkg::*;

  logic [DIV_W-1:0]    speed_divider;
  logic [SCROLL_W-1:0] scroll_last;

  logic [LINE_W-1:0]   scan_line;
  logic [DIV_W-1:0]    divider_count;
  logic [SCROLL_W-1:0] scroll_offset;
  logic [MODE_W-1:0]   mode_index;

  logic                s1_valid;
  logic [LINE_W-1:0]   s1_line;
  logic [MODE_W-1:0]   s1_mode;
  logic [7:0]          s1_column;

  logic                accept;
  logic                tick;
  logic                s1_move;
  logic                write_en;
  logic [ADDR_W-1:0]   write_addr;
  logic [ADDR_W-1:0]   read_addr;
  logic [CMP_W-1:0]    index_sum;

  logic [LINE_W-1:0]   scan_line_next;
  logic [DIV_W-1:0]    divider_count_next;
  logic [SCROLL_W-1:0] scroll_offset_next;
  logic [MODE_W-1:0]   mode_index_next;

  logic [7:0]          d;
  logic [7:0]          nd;
  logic [7:0]          row_next;
  logic [7:0]          second_next;

  // Handshake: the line stage moves when the output register is free
  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_move;
  assign accept   = in_valid && !in_stall;
  assign tick     = accept && (command == CMD_TICK);

  // Write the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_divider <= SPEED_DIVIDER_RESET;
      scroll_last   <= SCROLL_LAST_RESET;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        REG_SPEED_DIVIDER: speed_divider <= cfg_data;
        REG_SCROLL_LAST:   scroll_last   <= cfg_data[SCROLL_W-1:0];
        default:           ;
      endcase
    end
  end

  // Drop writes beyond the store; wrap the scan index around the store
  assign write_en   = accept && (command == CMD_WRITE) &&
                      (CMP_W'(address) < CMP_W'(PATTERN_DEPTH));
  assign write_addr = ADDR_W'(address);
  assign index_sum  = CMP_W'(scan_line) + CMP_W'(scroll_offset);
  assign read_addr  = index_sum[ADDR_W-1:0];

  lmss_column_store u_store (
    .clk        (clk),
    .rst        (rst),
    .write_en   (write_en),
    .write_addr (write_addr),
    .write_data (pattern_byte),
    .read_en    (tick),
    .read_addr  (read_addr),
    .read_data  (s1_column)
  );

  // Advance line, divider, scroll and mode for one tick
  always_comb begin
    scan_line_next     = scan_line + LINE_W'(1);
    divider_count_next = divider_count;
    scroll_offset_next = scroll_offset;
    mode_index_next    = mode_index;
    if (divider_count >= speed_divider) begin
      divider_count_next = '0;
      if (scroll_offset >= scroll_last) begin
        scroll_offset_next = '0;
        if (mode_index >= MODE_LAST) begin
          mode_index_next = '0;
        end else begin
          mode_index_next = mode_index + MODE_W'(1);
        end
      end else begin
        scroll_offset_next = scroll_offset + SCROLL_W'(1);
      end
    end else begin
      divider_count_next = divider_count + DIV_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_line     <= '0;
      divider_count <= '0;
      scroll_offset <= '0;
      mode_index    <= '0;
    end else if (tick) begin
      scan_line     <= scan_line_next;
      divider_count <= divider_count_next;
      scroll_offset <= scroll_offset_next;
      mode_index    <= mode_index_next;
    end
  end

  // Hold the line and mode alongside the store read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept || s1_move) begin
      s1_valid <= tick;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      s1_line <= scan_line;
      s1_mode <= mode_index;
    end
  end

  // Map the column onto the two row drives
  assign d  = flip_bits(~s1_column);
  assign nd = ~d;

  always_comb begin
    case (s1_mode)
      MODE_D_FF:  begin row_next = d;     second_next = 8'hff; end
      MODE_FF_D:  begin row_next = 8'hff; second_next = d;     end
      MODE_D_D:   begin row_next = d;     second_next = d;     end
      MODE_ND_FF: begin row_next = nd;    second_next = 8'hff; end
      MODE_00_D:  begin row_next = 8'h00; second_next = d;     end
      MODE_ND_D:  begin row_next = nd;    second_next = d;     end
      MODE_00_ND: begin row_next = 8'h00; second_next = nd;    end
      MODE_ND_ND: begin row_next = nd;    second_next = nd;    end
      MODE_ND_00: begin row_next = nd;    second_next = 8'h00; end
      MODE_D_ND:  begin row_next = d;     second_next = nd;    end
      MODE_D_00:  begin row_next = d;     second_next = 8'h00; end
      MODE_FF_ND: begin row_next = 8'hff; second_next = nd;    end
      default:    begin row_next = 8'hff; second_next = 8'hff; end
    endcase
  end

  // Load the output register; clear valid once the result is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      row_drive    <= row_next;
      second_drive <= second_next;
      scan_select  <= ~(8'h01 << s1_line);
      color_mode   <= s1_mode;
    end
  end

endmodule
